// File: rtl/core/wss_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard signature scan: shared types and constants
// Payload structs for the byte and result channels, the configuration
// register set and the CSR index codes.
// ----------------------------------------------------------------------------
package wss_pkg;

   localparam int MAX_PATTERN_BYTES_DEFAULT = 16;
   localparam int CFG_PATTERN_SLOTS         = 16;

   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_CARE_MASK    = 3'd2,
      CSR_PATTERN_LEN  = 3'd3,
      CSR_SEARCH_START = 3'd4,
      CSR_SEARCH_END   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  byte_value;
      logic [63:0] byte_address;
      logic        region_first;
      logic        search_last;
   } req_payload_type;

   typedef struct packed {
      logic        found;
      logic [63:0] match_address;
      logic        range_error;
   } rsp_payload_type;

   typedef struct packed {
      logic [63:0] pattern_bytes_low;
      logic [63:0] pattern_bytes_high;
      logic [15:0] care_mask;
      logic [4:0]  pattern_length;
      logic [63:0] search_start;
      logic [63:0] search_end;
   } cfg_type;

endpackage

// File: rtl/core/wss_csr.sv
// ----------------------------------------------------------------------------
// Wildcard signature scan: configuration registers
// APB-style register file holding pattern, care mask, length and the
// search window bounds; registers sit at 8-byte strides.
// ----------------------------------------------------------------------------
module wss_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [wss_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [wss_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [wss_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output wss_pkg::cfg_type                   cfg
);
   import wss_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          write_en;
   csr_index_type index;

   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_INDEX_W]);
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            CSR_PATTERN_LOW:  cfg_in.pattern_bytes_low  = csr_pwdata;
            CSR_PATTERN_HIGH: cfg_in.pattern_bytes_high = csr_pwdata;
            CSR_CARE_MASK:    cfg_in.care_mask          = csr_pwdata[15:0];
            CSR_PATTERN_LEN:  cfg_in.pattern_length     = csr_pwdata[4:0];
            CSR_SEARCH_START: cfg_in.search_start       = csr_pwdata;
            CSR_SEARCH_END:   cfg_in.search_end         = csr_pwdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_PATTERN_LOW:  csr_prdata = cfg_ff.pattern_bytes_low;
         CSR_PATTERN_HIGH: csr_prdata = cfg_ff.pattern_bytes_high;
         CSR_CARE_MASK:    csr_prdata = {48'd0, cfg_ff.care_mask};
         CSR_PATTERN_LEN:  csr_prdata = {59'd0, cfg_ff.pattern_length};
         CSR_SEARCH_START: csr_prdata = cfg_ff.search_start;
         CSR_SEARCH_END:   csr_prdata = cfg_ff.search_end;
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_bytes_low  <= 64'd0;
         cfg_ff.pattern_bytes_high <= 64'd0;
         cfg_ff.care_mask          <= 16'hFFFF;
         cfg_ff.pattern_length     <= 5'd1;
         cfg_ff.search_start       <= 64'd0;
         cfg_ff.search_end         <= 64'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/core/wildcard_signature_scan_core.sv
// ----------------------------------------------------------------------------
// Wildcard signature scan core
// Slides a byte window over a memory stream and latches the first in-range
// match of a masked byte pattern; reports it on the last byte of a search.
//
//   channel   direction  handshake          content
//   req_      in         valid / stall      one memory byte with address, flags
//   rsp_      out        valid / stall      found, match address, range error
//   csr_      in         APB-style          pattern, care mask, length, bounds
//
// One byte is taken every cycle while req_stall is low; the input register
// and the result register bracket a single compare stage, so a byte marked
// search_last passes through both, input register first, before rsp_valid rises.
// rsp_stall only holds the input when a byte marked search_last finds the
// result register still occupied; other bytes keep flowing.
// Reset is synchronous; the pattern window needs no clearing since the fill
// count gates every compare.
// ----------------------------------------------------------------------------
module wildcard_signature_scan_core #(
   parameter int MAX_PATTERN_BYTES = wss_pkg::MAX_PATTERN_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  wss_pkg::req_payload_type           req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output wss_pkg::rsp_payload_type           rsp_payload,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [wss_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [wss_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [wss_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import wss_pkg::*;

   localparam int LIM    = (MAX_PATTERN_BYTES < CFG_PATTERN_SLOTS) ?
                           MAX_PATTERN_BYTES : CFG_PATTERN_SLOTS;
   localparam int FILL_W = $clog2(LIM + 1);

   cfg_type cfg;

   wss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input stage
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_payload_ff, s1_payload_in;
   logic [63:0]     s1_mstart_ff, s1_mstart_in;

   // search state
   logic [7:0]        window_ff [LIM];
   logic [7:0]        window_in [LIM];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              seen_ff, seen_in;
   logic [63:0]       first_addr_ff, first_addr_in;

   // result stage
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic              accept;
   logic              rsp_slot_free;
   logic              s1_go;
   logic [FILL_W-1:0] len_eff;
   logic [FILL_W-1:0] fill_base;
   logic [FILL_W-1:0] fill_next;
   logic [127:0]      pat_bytes;
   logic [LIM-1:0]    len_match;
   logic              hit;
   logic              in_range;
   logic              new_match;
   logic              seen_next;
   logic [63:0]       addr_next;
   logic              range_err;

   // effective pattern length: zero acts as one, clip to the window size
   always_comb begin
      if (cfg.pattern_length == 5'd0) begin
         len_eff = FILL_W'(1);
      end else if (cfg.pattern_length > 5'(LIM)) begin
         len_eff = FILL_W'(LIM);
      end else begin
         len_eff = cfg.pattern_length[FILL_W-1:0];
      end
   end

   assign rsp_slot_free = !rsp_valid_ff || !rsp_stall;
   assign s1_go         = s1_valid_ff && (!s1_payload_ff.search_last || rsp_slot_free);
   assign req_stall     = s1_valid_ff && !s1_go;
   assign accept        = req_valid && !req_stall;
   assign range_err     = cfg.search_end <= cfg.search_start;
   assign pat_bytes     = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};

   // input register; match start is precomputed here to shorten the stage
   always_comb begin
      s1_valid_in   = req_stall ? s1_valid_ff : req_valid;
      s1_payload_in = accept ? req_payload : s1_payload_ff;
      s1_mstart_in  = accept ? (req_payload.byte_address - (64'(len_eff) - 64'd1))
                             : s1_mstart_ff;
   end

   // window after taking the current byte, index 0 newest
   always_comb begin
      for (int k = 0; k < LIM; k++) begin
         if (!s1_go) begin
            window_in[k] = window_ff[k];
         end else if (k == 0) begin
            window_in[k] = s1_payload_ff.byte_value;
         end else begin
            window_in[k] = window_ff[(k > 0) ? k - 1 : 0];
         end
      end
   end

   assign fill_base = s1_payload_ff.region_first ? '0 : fill_ff;
   assign fill_next = (fill_base < FILL_W'(LIM)) ? fill_base + FILL_W'(1) : fill_base;

   // one masked compare per candidate length, then pick the configured one
   always_comb begin
      logic ok;
      ok = 1'b1;
      for (int l = 1; l <= LIM; l++) begin
         ok = 1'b1;
         for (int j = 0; j < l; j++) begin
            if (cfg.care_mask[j] && (window_in[l-1-j] != pat_bytes[8*j +: 8])) begin
               ok = 1'b0;
            end
         end
         len_match[l-1] = ok;
      end
   end

   always_comb begin
      hit = 1'b0;
      for (int l = 1; l <= LIM; l++) begin
         if (len_eff == FILL_W'(l)) begin
            hit = len_match[l-1];
         end
      end
   end

   assign in_range  = (s1_mstart_ff >= cfg.search_start) && (s1_mstart_ff < cfg.search_end);
   assign new_match = !seen_ff && (fill_next >= len_eff) && in_range && hit;
   assign seen_next = seen_ff || new_match;
   assign addr_next = new_match ? s1_mstart_ff : first_addr_ff;

   always_comb begin
      fill_in       = fill_ff;
      seen_in       = seen_ff;
      first_addr_in = first_addr_ff;
      if (s1_go) begin
         if (s1_payload_ff.search_last) begin
            // drop the search state once its result is out
            fill_in       = '0;
            seen_in       = 1'b0;
            first_addr_in = 64'd0;
         end else begin
            fill_in       = fill_next;
            seen_in       = seen_next;
            first_addr_in = addr_next;
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_slot_free) begin
         rsp_valid_in = s1_go && s1_payload_ff.search_last;
      end
      if (s1_go && s1_payload_ff.search_last) begin
         rsp_payload_in.found         = seen_next;
         rsp_payload_in.match_address = seen_next ? addr_next : 64'd0;
         rsp_payload_in.range_error   = range_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         fill_ff       <= '0;
         seen_ff       <= 1'b0;
         first_addr_ff <= 64'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         fill_ff       <= fill_in;
         seen_ff       <= seen_in;
         first_addr_ff <= first_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_payload_ff  <= s1_payload_in;
      s1_mstart_ff   <= s1_mstart_in;
      rsp_payload_ff <= rsp_payload_in;
      for (int k = 0; k < LIM; k++) begin
         window_ff[k] <= window_in[k];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
